[rtl/rfca_pkg.sv]
`default_nettype none
package rfca_pkg;

    localparam int CELLS_DEF = 4096;
    localparam int WORD_BITS = 32;
    localparam int WORD_OW   = 5;
    localparam int VAL_W     = 31;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic OP_TAKE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic             op;
        logic [VAL_W-1:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               grid_full;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/rfca_div.sv]
`default_nettype none
module rfca_div #(
    parameter int DW = 31,
    parameter int SW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [SW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot,
    output logic [SW-1:0]      o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [SW-1:0] r_r;
    logic [SW-1:0] r_d;
    logic [SW:0]   trial;
    logic          fits;

    assign trial = {r_r, r_q[DW-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_r <= SW'(trial - {1'b0, r_d});
            end else begin
                r_r <= trial[SW-1:0];
            end
            r_q <= {r_q[DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

[rtl/random_free_cell_allocator_unit.sv]
`default_nettype none
// Random free cell allocator.
// Input channel (i_in_valid/o_in_ready, i_in_item): op take or clear, plus a
// random value. Output channel (o_out_valid/i_out_ready, o_out_item): one item
// per take (row, column, grid_full), none per clear.
// Grid size is set over the APB port: grid_rows at 0x0, grid_cols at 0x4.
// The occupancy bitmap lives in a single memory of 32-bit words.
// A take runs two 31-step shift-subtract divisions (start modulo size,
// index by columns) in the shared divider and reads the bitmap one word
// per visit.
// A take that finds the grid full skips the divisions and the bitmap read.
// A clear, and reset, sweep the bitmap one word a cycle, ceil(CELLS/32)
// words, during which no item is accepted; APB writes are still taken.
// One item is in work at a time. A finished result sits in the output
// register; the next item is accepted while it waits. If the receiver
// stalls, the result holds and a following result waits in the block.
module random_free_cell_allocator_unit #(
    parameter int CELLS = rfca_pkg::CELLS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire rfca_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output rfca_pkg::t_out_item      o_out_item
);
    localparam int W      = rfca_pkg::WORD_BITS;
    localparam int OW     = rfca_pkg::WORD_OW;
    localparam int NWORDS = (CELLS + W - 1) / W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SIW    = AW + OW;
    localparam int NW     = $clog2(CELLS + 1);
    localparam int SW     = (NW > rfca_pkg::DIM_W) ? NW : rfca_pkg::DIM_W;
    localparam int DW     = rfca_pkg::VAL_W;
    localparam int PW     = 2 * rfca_pkg::DIM_W;
    localparam int CW     = rfca_pkg::COORD_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLR   = 9'b000000010,
        S_SIZE  = 9'b000000100,
        S_START = 9'b000001000,
        S_MOD   = 9'b000010000,
        S_RD    = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_RC    = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state  r_state, n_state;

    logic [rfca_pkg::DIM_W-1:0] r_rows, r_cols;
    logic [DW-1:0]              r_rv;
    logic [NW-1:0]              r_size;
    logic [NW-1:0]              r_used;
    logic [SIW-1:0]             r_start;
    logic [AW-1:0]              r_addr;
    logic [AW-1:0]              r_caddr;
    logic                       r_first;
    logic                       r_wrap;
    rfca_pkg::t_out_item        r_res;
    rfca_pkg::t_out_item        r_out;
    logic                       r_ovalid;

    logic [W-1:0] r_mem [NWORDS];
    logic [W-1:0] r_rdata;
    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0] mem_wdata;

    logic          in_acc;
    logic          cfg_wr;
    logic [PW-1:0] prod;
    logic          is_full;
    logic [SIW-1:0] nm1;
    logic [AW-1:0] last_word;
    logic [OW-1:0] last_bit;
    logic [OW-1:0] start_bit;
    logic          final_visit;
    logic [W-1:0]  mask;
    logic [W-1:0]  free_bits;
    logic          found;
    logic [OW-1:0] hit_bit;
    logic [SIW-1:0] hit_idx;
    logic          out_free;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [SW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [SW-1:0] div_rem;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    always_comb begin
        case (paddr[2])
            rfca_pkg::REG_ROWS: prdata = {{(32 - rfca_pkg::DIM_W){1'b0}}, r_rows};
            rfca_pkg::REG_COLS: prdata = {{(32 - rfca_pkg::DIM_W){1'b0}}, r_cols};
            default:            prdata = '0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
    assign out_free    = !r_ovalid || i_out_ready;

    assign prod    = {{rfca_pkg::DIM_W{1'b0}}, r_rows} * {{rfca_pkg::DIM_W{1'b0}}, r_cols};
    assign is_full = (r_size == '0) || (r_used >= r_size);

    assign nm1         = SIW'(r_size) - SIW'(1);
    assign last_word   = nm1[SIW-1:OW];
    assign last_bit    = nm1[OW-1:0];
    assign start_bit   = r_start[OW-1:0];
    assign final_visit = r_wrap && (r_addr == r_start[SIW-1:OW]);

    always_comb begin
        mask = '1;
        if (r_addr == last_word) begin
            mask = mask & ~(({W{1'b1}} << last_bit) << 1);
        end
        if (r_first) begin
            mask = mask & ({W{1'b1}} << start_bit);
        end
        if (final_visit) begin
            mask = mask & ~({W{1'b1}} << start_bit);
        end
    end

    assign free_bits = ~r_rdata & mask;
    assign found     = |free_bits;

    always_comb begin
        hit_bit = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                hit_bit = OW'(i);
            end
        end
    end

    assign hit_idx = {r_addr, hit_bit};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata | (W'(1) << hit_bit);
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_caddr;
            mem_wdata = '0;
        end else if (r_state == S_CHK && found) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_rv;
        div_divisor  = SW'(r_size);
        if (r_state == S_START && !is_full) begin
            div_start = 1'b1;
        end else if (r_state == S_CHK && found) begin
            div_start    = 1'b1;
            div_dividend = DW'(hit_idx);
            div_divisor  = SW'(r_cols);
        end
    end

    rfca_div #(
        .DW (DW),
        .SW (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_item.op == rfca_pkg::OP_CLEAR) ? S_CLR : S_SIZE;
                end
            end
            S_CLR: begin
                if (r_caddr == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SIZE:  n_state = S_START;
            S_START: n_state = is_full ? S_OUT : S_MOD;
            S_MOD: begin
                if (div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD:    n_state = S_CHK;
            S_CHK: begin
                if (found) begin
                    n_state = S_RC;
                end else if (final_visit) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RC: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_caddr  <= '0;
            r_used   <= '0;
            r_rows   <= rfca_pkg::DIM_W'(1);
            r_cols   <= rfca_pkg::DIM_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[2])
                    rfca_pkg::REG_ROWS: r_rows <= pwdata[rfca_pkg::DIM_W-1:0];
                    rfca_pkg::REG_COLS: r_cols <= pwdata[rfca_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc && i_in_item.op == rfca_pkg::OP_CLEAR) begin
                r_caddr <= '0;
                r_used  <= '0;
            end else if (r_state == S_CLR) begin
                r_caddr <= r_caddr + AW'(1);
            end
            if (r_state == S_CHK && found) begin
                r_used <= r_used + NW'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rv <= i_in_item.random_value;
        end
        if (r_state == S_SIZE) begin
            r_size <= (prod > PW'(CELLS)) ? NW'(CELLS) : NW'(prod);
        end
        if (r_state == S_START) begin
            r_res.cell_row  <= '0;
            r_res.cell_col  <= '0;
            r_res.grid_full <= 1'b1;
        end
        if (r_state == S_MOD && div_done) begin
            r_start <= SIW'(div_rem);
            r_addr  <= AW'(SIW'(div_rem) >> OW);
            r_first <= 1'b1;
            r_wrap  <= 1'b0;
        end
        if (r_state == S_CHK && !found) begin
            r_first <= 1'b0;
            if (r_addr == last_word) begin
                r_addr <= '0;
                r_wrap <= 1'b1;
            end else begin
                r_addr <= r_addr + AW'(1);
            end
        end
        if (r_state == S_RC && div_done) begin
            r_res.cell_row  <= div_quot[CW-1:0];
            r_res.cell_col  <= div_rem[CW-1:0];
            r_res.grid_full <= 1'b0;
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end
endmodule
`default_nettype wire

[rtl/rfca_chk.sv]
`default_nettype none
module rfca_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire rfca_pkg::t_out_item o_out_item
);
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or valid high right after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while one is in work");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.grid_full |->
            o_out_item.cell_row == '0 && o_out_item.cell_col == '0)
        else $error("full result carries a cell");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result dropped or changed");
endmodule

bind random_free_cell_allocator_unit rfca_chk u_rfca_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

[bench/tb_random_free_cell_allocator_unit.sv]
`timescale 1ns / 100ps
module tb_random_free_cell_allocator_unit;

    localparam int CELLS        = rfca_pkg::CELLS_DEF;
    localparam int IDLE_DRAIN   = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 420;
    localparam rfca_pkg::t_out_item NO_CELL =
        '{cell_row: '0, cell_col: '0, grid_full: 1'b1};

    typedef struct {
        bit                  set_grid;
        int unsigned         rows;
        int unsigned         cols;
        rfca_pkg::t_in_item  item;
        bit                  typed;
        rfca_pkg::t_out_item want;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    rfca_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    rfca_pkg::t_out_item o_out_item;

    random_free_cell_allocator_unit #(.CELLS(CELLS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // allocator shadow state
    bit          occ_map [0:CELLS-1];
    int unsigned used_cells = 0;
    int unsigned rows_m = 1;
    int unsigned cols_m = 1;

    rfca_pkg::t_out_item pending_cells [$];
    int unsigned mismatch_cnt = 0;
    bit          calm_phase = 1'b0;
    int unsigned out_hold = 0;
    int unsigned quiet_cycles = 0;
    t_stim_row   script [$];

    function automatic bit predict_alloc(input rfca_pkg::t_in_item it,
                                         output rfca_pkg::t_out_item res);
        int unsigned n;
        int unsigned idx;
        res = NO_CELL;
        if (it.op == rfca_pkg::OP_CLEAR) begin
            foreach (occ_map[k]) occ_map[k] = 1'b0;
            used_cells = 0;
            return 1'b0;
        end
        n = rows_m * cols_m;
        if (n > CELLS) n = CELLS;
        if (n == 0 || used_cells >= n) return 1'b1;
        idx = it.random_value % n;
        for (int unsigned t = 0; t < n; t++) begin
            if (!occ_map[idx]) begin
                occ_map[idx] = 1'b1;
                used_cells++;
                res.cell_row  = rfca_pkg::COORD_W'(idx / cols_m);
                res.cell_col  = rfca_pkg::COORD_W'(idx % cols_m);
                res.grid_full = 1'b0;
                return 1'b1;
            end
            idx = (idx + 1 >= n) ? 0 : idx + 1;
        end
        return 1'b1;
    endfunction

    function automatic rfca_pkg::t_out_item cell_at(int unsigned r, int unsigned c);
        rfca_pkg::t_out_item o;
        o.cell_row  = rfca_pkg::COORD_W'(r);
        o.cell_col  = rfca_pkg::COORD_W'(c);
        o.grid_full = 1'b0;
        return o;
    endfunction

    function automatic t_stim_row grid(int unsigned r, int unsigned c);
        t_stim_row s;
        s.set_grid = 1'b1;
        s.rows     = r;
        s.cols     = c;
        s.item     = '0;
        s.typed    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    function automatic t_stim_row take_typed(logic [rfca_pkg::VAL_W-1:0] rv,
                                             rfca_pkg::t_out_item want);
        t_stim_row s;
        s.set_grid          = 1'b0;
        s.rows              = 0;
        s.cols              = 0;
        s.item.op           = rfca_pkg::OP_TAKE;
        s.item.random_value = rv;
        s.typed             = 1'b1;
        s.want              = want;
        return s;
    endfunction

    function automatic t_stim_row take(logic [rfca_pkg::VAL_W-1:0] rv);
        t_stim_row s;
        s       = take_typed(rv, '0);
        s.typed = 1'b0;
        return s;
    endfunction

    function automatic t_stim_row wipe();
        t_stim_row s;
        s         = take(0);
        s.item.op = rfca_pkg::OP_CLEAR;
        return s;
    endfunction

    task automatic apb_write(logic reg_idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == rfca_pkg::REG_ROWS) rows_m = value & 32'h1FFF;
        else cols_m = value & 32'h1FFF;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (IDLE_DRAIN) @(posedge i_clk);
    endtask

    task automatic set_grid(int unsigned r, int unsigned c);
        wait_idle();
        apb_write(rfca_pkg::REG_ROWS, r);
        apb_write(rfca_pkg::REG_COLS, c);
    endtask

    task automatic send_item(rfca_pkg::t_in_item it, bit typed,
                             rfca_pkg::t_out_item want, bit pause);
        int unsigned         gap;
        rfca_pkg::t_out_item p;
        gap = calm_phase ? 0 : $urandom_range(0, 4);
        if (gap != 0 || (pause && pending_cells.size() != 0)) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (pause) while (pending_cells.size() != 0) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_alloc(it, p)) pending_cells.push_back(typed ? want : p);
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) out_hold = calm_phase ? 0 : $urandom_range(0, 4);
        else if (out_hold != 0) out_hold--;
        i_out_ready <= (out_hold == 0);
    end

    always @(posedge i_clk) begin
        rfca_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected item row %0d col %0d full %0d", $realtime,
                         o_out_item.cell_row, o_out_item.cell_col, o_out_item.grid_full);
                mismatch_cnt++;
            end else begin
                e = pending_cells.pop_front();
                if (o_out_item.cell_row !== e.cell_row) begin
                    $display("%0t: cell_row expected %0d got %0d", $realtime,
                             e.cell_row, o_out_item.cell_row);
                    mismatch_cnt++;
                end
                if (o_out_item.cell_col !== e.cell_col) begin
                    $display("%0t: cell_col expected %0d got %0d", $realtime,
                             e.cell_col, o_out_item.cell_col);
                    mismatch_cnt++;
                end
                if (o_out_item.grid_full !== e.grid_full) begin
                    $display("%0t: grid_full expected %0d got %0d", $realtime,
                             e.grid_full, o_out_item.grid_full);
                    mismatch_cnt++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable && pwrite && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        rfca_pkg::t_in_item it;
        int unsigned        sent;
        int unsigned        n_items;
        int unsigned        kind;
        int unsigned        r;
        int unsigned        c;

        foreach (occ_map[k]) occ_map[k] = 1'b0;

        script.push_back(take_typed(0, cell_at(0, 0)));
        script.push_back(take_typed(31'h7FFFFFFF, NO_CELL));
        script.push_back(wipe());
        script.push_back(take_typed(31'h7FFFFFFF, cell_at(0, 0)));
        script.push_back(grid(0, 5));
        script.push_back(take_typed(3, NO_CELL));
        script.push_back(grid(3, 0));
        script.push_back(take_typed(31'h7FFFFFFF, NO_CELL));
        script.push_back(grid(4096, 4096));
        script.push_back(take_typed(31'h7FFFFFFF, cell_at(0, 4095)));
        script.push_back(take_typed(4095, cell_at(0, 1)));
        script.push_back(take_typed(0, cell_at(0, 2)));
        script.push_back(wipe());
        script.push_back(grid(8191, 1));
        script.push_back(take_typed(4095, cell_at(4095, 0)));
        script.push_back(take(31'h2AAAAAAA));
        script.push_back(grid(1, 4096));
        script.push_back(take(31'h55555555));
        script.push_back(wipe());
        script.push_back(grid(2, 3));
        script.push_back(take(5));
        script.push_back(take(5));
        script.push_back(take(31'h7FFFFFFF));
        script.push_back(take(12));
        script.push_back(take(1));
        script.push_back(take(3));
        script.push_back(take_typed(0, NO_CELL));
        // shrink without clearing
        script.push_back(grid(1, 2));
        script.push_back(take_typed(1, NO_CELL));
        script.push_back(grid(4, 4));
        script.push_back(take(9));
        script.push_back(take(31'h7FFFFFFF));
        script.push_back(wipe());

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].set_grid) set_grid(script[k].rows, script[k].cols);
            else send_item(script[k].item, script[k].typed, script[k].want, 1'b0);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    r = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    c = (r == 0) ? $urandom_range(0, 8) : 0;
                end
                1: begin
                    r = $urandom_range(1, 4096);
                    c = $urandom_range(1, 4096);
                end
                2: begin
                    case ($urandom_range(0, 2))
                        0: begin r = 4096; c = 1; end
                        1: begin r = 1; c = 4096; end
                        default: begin r = 8191; c = 8191; end
                    endcase
                end
                default: begin
                    r = $urandom_range(1, 6);
                    c = $urandom_range(1, 6);
                end
            endcase
            set_grid(r, c);
            calm_phase = ($urandom_range(0, 4) == 0);
            n_items = $urandom_range(10, 40);
            repeat (n_items) begin
                it.op = ($urandom_range(0, 11) == 0) ? rfca_pkg::OP_CLEAR : rfca_pkg::OP_TAKE;
                case ($urandom_range(0, 15))
                    0: it.random_value = '0;
                    1: it.random_value = '1;
                    default: it.random_value = rfca_pkg::VAL_W'($urandom);
                endcase
                send_item(it, 1'b0, '0, (sent == 60) || ($urandom_range(0, 49) == 0));
                sent++;
            end
        end
        calm_phase = 1'b0;

        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
